// ----- rtl/core/bounded_positional_list_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded positional list
// Each macro expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_POSITIONAL_LIST_ASSERT_SVH
`define BOUNDED_POSITIONAL_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bounded_positional_list: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bounded_positional_list: assertion failed");

`endif

// ----- rtl/core/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg
// Types and codes shared by the bounded positional list and its cells.
// ----------------------------------------------------------------------------
package bpl_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	// Wide enough for any length or position up to the largest capacity plus one.
	localparam int IDX_W  = 7;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [2:0] {
		K_INS_HEAD = 3'd0,
		K_INS_TAIL = 3'd1,
		K_INS_POS  = 3'd2,
		K_DEL_POS  = 3'd3,
		K_DEL_HEAD = 3'd4,
		K_DEL_TAIL = 3'd5,
		K_DISPLAY  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_RANGE   = 3'd2,
		ST_INVALID = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_DISP = 1'b1
	} fsm_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	// Broadcast to every cell of the chain in each cycle.
	typedef struct packed {
		cell_op_t op;
		idx_t     idx;
		word_t    wdata;
		word_t    head;
	} cell_ctl_t;

endpackage

// ----- rtl/core/bpl_cell.sv -----
// ----------------------------------------------------------------------------
// bpl_cell
// One slot of the list; takes its left or right neighbor, the new word, or
// the head word, depending on the broadcast operation and its own position.
// ----------------------------------------------------------------------------
module bpl_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  bpl_pkg::cell_ctl_t ctl,
	input  bpl_pkg::word_t     left,
	input  bpl_pkg::word_t     right,
	output bpl_pkg::word_t     data_q
);

	localparam bpl_pkg::idx_t MY_IDX = bpl_pkg::IDX_W'(IDX);

	bpl_pkg::word_t data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			bpl_pkg::CELL_INS: begin
				if (MY_IDX > ctl.idx) begin
					data_d = left;
				end else if (MY_IDX == ctl.idx) begin
					data_d = ctl.wdata;
				end
			end
			bpl_pkg::CELL_DEL: begin
				if (MY_IDX >= ctl.idx) begin
					data_d = right;
				end
			end
			bpl_pkg::CELL_ROT: begin
				// The tail slot takes the old head, closing the circle.
				if (MY_IDX < ctl.idx) begin
					data_d = right;
				end else if (MY_IDX == ctl.idx) begin
					data_d = ctl.head;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ----- rtl/core/bounded_positional_list.sv -----
// ----------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of up to CAPACITY signed words held in a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)         | tuser | tlast
//  s_*     | in  | value[31:0], position[37:32]  | kind  | -
//  m_*     | out | status[2:0], entry[34:3]      | -     | last
//
// A change operation is applied when it is taken; its status item is registered
// and offered in the next cycle. In display, each entry is read from the head
// slot while the circular rotation of the cell chain restores the order.
// Input is taken only when no display runs and the output register is free
// or being emptied. A stalled output holds the chain. Reset clears the length
// and control state; cell contents are left as they are.
module bounded_positional_list #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // value, position, zero fill
	input  logic [2:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // status, entry, zero fill
	output logic        m_tlast
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int MW = 40;
	localparam int PW = 3 + bpl_pkg::DATA_W;

	bpl_pkg::fsm_t      state_q, state_d;
	logic [LW-1:0]      len_q, len_d;
	logic [LW-1:0]      cnt_q, cnt_d;
	logic               out_valid_q;
	bpl_pkg::status_t   out_status_q;
	bpl_pkg::word_t     out_entry_q;
	logic               out_last_q;

	logic               out_free, acc, full, empty, disp_last, load;
	bpl_pkg::status_t   ld_status;
	bpl_pkg::word_t     ld_entry;
	logic               ld_last;
	bpl_pkg::kind_t     kind;
	bpl_pkg::word_t     value;
	logic [bpl_pkg::POS_W-1:0] pos;
	bpl_pkg::idx_t      pos_x, len_x;
	bpl_pkg::cell_ctl_t ctl;
	bpl_pkg::word_t     cell_q [CAPACITY];

	assign kind  = bpl_pkg::kind_t'(s_tuser);
	assign value = s_tdata[31:0];
	assign pos   = s_tdata[37:32];
	assign pos_x = bpl_pkg::idx_t'(pos);
	assign len_x = bpl_pkg::idx_t'(len_q);

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == bpl_pkg::S_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign full      = (len_q == LW'(CAPACITY));
	assign empty     = (len_q == '0);
	assign disp_last = (cnt_q == len_q - LW'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpl_pkg::S_IDLE: begin
				if (acc && kind == bpl_pkg::K_DISPLAY && !empty) begin
					state_d = bpl_pkg::S_DISP;
				end
			end
			bpl_pkg::S_DISP: begin
				if (out_free && disp_last) begin
					state_d = bpl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.op    = bpl_pkg::CELL_HOLD;
		ctl.idx   = '0;
		ctl.wdata = value;
		ctl.head  = cell_q[0];
		len_d     = len_q;
		cnt_d     = cnt_q;
		load      = 1'b0;
		ld_status = bpl_pkg::ST_OK;
		ld_entry  = '0;
		ld_last   = 1'b1;
		case (state_q)
			bpl_pkg::S_IDLE: begin
				if (acc) begin
					load = 1'b1;
					case (kind)
						bpl_pkg::K_INS_HEAD, bpl_pkg::K_INS_TAIL: begin
							if (full) begin
								ld_status = bpl_pkg::ST_FULL;
							end else begin
								ctl.op  = bpl_pkg::CELL_INS;
								ctl.idx = (kind == bpl_pkg::K_INS_HEAD) ? '0 : len_x;
								len_d   = len_q + LW'(1);
							end
						end
						bpl_pkg::K_INS_POS: begin
							if (pos == '0) begin
								ld_status = bpl_pkg::ST_INVALID;
							end else if (full) begin
								ld_status = bpl_pkg::ST_FULL;
							end else if (pos_x > len_x + bpl_pkg::IDX_W'(1)) begin
								ld_status = bpl_pkg::ST_RANGE;
							end else begin
								ctl.op  = bpl_pkg::CELL_INS;
								ctl.idx = pos_x - bpl_pkg::IDX_W'(1);
								len_d   = len_q + LW'(1);
							end
						end
						bpl_pkg::K_DEL_POS: begin
							if (empty) begin
								ld_status = bpl_pkg::ST_EMPTY;
							end else if (pos == '0) begin
								ld_status = bpl_pkg::ST_INVALID;
							end else if (pos_x > len_x) begin
								ld_status = bpl_pkg::ST_RANGE;
							end else begin
								ctl.op  = bpl_pkg::CELL_DEL;
								ctl.idx = pos_x - bpl_pkg::IDX_W'(1);
								len_d   = len_q - LW'(1);
							end
						end
						bpl_pkg::K_DEL_HEAD: begin
							if (empty) begin
								ld_status = bpl_pkg::ST_EMPTY;
							end else begin
								ctl.op  = bpl_pkg::CELL_DEL;
								ctl.idx = '0;
								len_d   = len_q - LW'(1);
							end
						end
						bpl_pkg::K_DEL_TAIL: begin
							// Dropping the tail only shortens the list.
							if (empty) begin
								ld_status = bpl_pkg::ST_EMPTY;
							end else begin
								len_d = len_q - LW'(1);
							end
						end
						bpl_pkg::K_DISPLAY: begin
							if (empty) begin
								ld_status = bpl_pkg::ST_EMPTY;
							end else begin
								load  = 1'b0;
								cnt_d = '0;
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			bpl_pkg::S_DISP: begin
				if (out_free) begin
					load     = 1'b1;
					ld_entry = cell_q[0];
					ld_last  = disp_last;
					ctl.op   = bpl_pkg::CELL_ROT;
					ctl.idx  = len_x - bpl_pkg::IDX_W'(1);
					cnt_d    = cnt_q + LW'(1);
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			bpl_pkg::word_t left_w, right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_left
				assign left_w = cell_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_right
				assign right_w = cell_q[gi+1];
			end
			bpl_cell #(
				.IDX(gi)
			) u_cell (
				.clk    (clk),
				.ctl    (ctl),
				.left   (left_w),
				.right  (right_w),
				.data_q (cell_q[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpl_pkg::S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= ld_status;
			out_entry_q  <= ld_entry;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(MW-PW){1'b0}}, out_entry_q, out_status_q};

	`include "bounded_positional_list_assert.svh"

	`BPL_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LW'(CAPACITY))
	`BPL_ASSERT_NEXT(a_len_only_on_accept, !acc, $stable(len_q))
	`BPL_ASSERT_NEXT(a_full_keeps_len, acc && full && (kind == bpl_pkg::K_INS_HEAD || kind == bpl_pkg::K_INS_TAIL || kind == bpl_pkg::K_INS_POS), $stable(len_q))
	`BPL_ASSERT_NEXT(a_change_answers, acc && kind != bpl_pkg::K_DISPLAY && s_tuser != 3'd7, m_tvalid && m_tlast)
	`BPL_ASSERT_NOW(a_disp_holds_input, state_q == bpl_pkg::S_DISP, !s_tready && !empty)

endmodule

// ----- tb/sv/tb_bounded_positional_list.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_positional_list
// Streams list operations into the bounded positional list and checks every
// status and display item against a queue-based model of the list contents.
// ----------------------------------------------------------------------------
module tb_bounded_positional_list;
	timeunit 1ns;
	timeprecision 1ps;

	import bpl_pkg::*;

	localparam int CAPACITY = 32;
	localparam int RANDOM_ITEMS = 405;
	localparam logic [2:0] KIND_NONE = 3'd7;

	// Mirrors the list contents and holds the items the block still owes.
	class list_scoreboard;
		typedef struct {
			status_t status;
			word_t   entry;
			logic    last;
		} list_result_t;

		word_t        slots[$];
		list_result_t owed_q[$];
		int           errors;

		function new();
			errors = 0;
		endfunction

		function void owe_status(status_t st);
			owed_q.push_back('{st, '0, 1'b1});
		endfunction

		function bit waiting();
			return owed_q.size() != 0;
		endfunction

		function void note_item(logic [2:0] kind, word_t value, logic [5:0] pos);
			int len;
			len = slots.size();
			case (kind)
				K_INS_HEAD: begin
					if (len >= CAPACITY) begin
						owe_status(ST_FULL);
					end else begin
						slots.push_front(value);
						owe_status(ST_OK);
					end
				end
				K_INS_TAIL: begin
					if (len >= CAPACITY) begin
						owe_status(ST_FULL);
					end else begin
						slots.push_back(value);
						owe_status(ST_OK);
					end
				end
				K_INS_POS: begin
					if (pos == 0) begin
						owe_status(ST_INVALID);
					end else if (len >= CAPACITY) begin
						owe_status(ST_FULL);
					end else if (int'(pos) > len + 1) begin
						owe_status(ST_RANGE);
					end else begin
						slots.insert(int'(pos) - 1, value);
						owe_status(ST_OK);
					end
				end
				K_DEL_POS: begin
					if (len == 0) begin
						owe_status(ST_EMPTY);
					end else if (pos == 0) begin
						owe_status(ST_INVALID);
					end else if (int'(pos) > len) begin
						owe_status(ST_RANGE);
					end else begin
						slots.delete(int'(pos) - 1);
						owe_status(ST_OK);
					end
				end
				K_DEL_HEAD: begin
					if (len == 0) begin
						owe_status(ST_EMPTY);
					end else begin
						void'(slots.pop_front());
						owe_status(ST_OK);
					end
				end
				K_DEL_TAIL: begin
					if (len == 0) begin
						owe_status(ST_EMPTY);
					end else begin
						void'(slots.pop_back());
						owe_status(ST_OK);
					end
				end
				K_DISPLAY: begin
					if (len == 0) begin
						owe_status(ST_EMPTY);
					end else begin
						for (int i = 0; i < len; i++)
							owed_q.push_back('{ST_OK, slots[i], (i == len - 1)});
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [39:0] data, logic last);
			list_result_t want;
			if (owed_q.size() == 0) begin
				$error("unexpected item: status %0d entry %0d last %0b",
					data[2:0], $signed(data[34:3]), last);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (data[2:0] !== 3'(want.status)) begin
				$error("status: expected %0d, actual %0d", want.status, data[2:0]);
				errors++;
			end
			if (data[34:3] !== want.entry) begin
				$error("entry: expected %0d, actual %0d",
					$signed(want.entry), $signed(data[34:3]));
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // value, position, zero fill
	logic [2:0]  s_tuser = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // status, entry, zero fill
	logic        m_tlast;

	bit             steady = 1'b0;
	list_scoreboard sb = new();

	bounded_positional_list #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);
		m_tready <= steady || ($urandom_range(99) >= 17);
	end

	// Called at a rising edge; returns at the edge where the item was taken.
	task automatic send_item(input logic [2:0] kind, input word_t value, input logic [5:0] pos);
		while (!steady && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, pos, value};
		do @(posedge clk); while (!s_tready);
		sb.note_item(kind, value, pos);
	endtask

	task automatic drain_list;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.waiting());
	endtask

	initial begin
		int         done_items;
		int         at_edge;
		int         len;
		int         r;
		bit         grow;
		logic [2:0] kind;
		logic [5:0] pos;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list corner cases first, then position, range and unknown-kind cases on a short list.
		send_item(K_DISPLAY,  32'h0, 6'd0);
		send_item(K_DEL_HEAD, 32'h0, 6'd0);
		send_item(K_DEL_TAIL, 32'h0, 6'd0);
		send_item(K_DEL_POS,  32'h0, 6'd0);
		send_item(K_DEL_POS,  32'h0, 6'd5);
		send_item(K_INS_POS,  32'h1234_5678, 6'd0);
		send_item(K_INS_POS,  32'h1234_5678, 6'd2);
		send_item(K_INS_POS,  32'h8000_0000, 6'd1);
		send_item(K_INS_HEAD, 32'h7fff_ffff, 6'd63);
		send_item(K_INS_TAIL, 32'hffff_ffff, 6'd0);
		send_item(K_INS_TAIL, 32'h0000_0000, 6'd0);
		send_item(K_INS_POS,  32'h5555_5555, 6'd5);
		send_item(K_INS_POS,  32'haaaa_aaaa, 6'd7);
		send_item(K_INS_POS,  32'haaaa_aaaa, 6'd63);
		send_item(K_DISPLAY,  32'h0, 6'd0);
		send_item(K_DEL_POS,  32'h0, 6'd0);
		send_item(K_DEL_POS,  32'h0, 6'd6);
		send_item(K_DEL_POS,  32'h0, 6'd63);
		send_item(K_DEL_POS,  32'h0, 6'd3);
		send_item(K_DEL_POS,  32'h0, 6'd4);
		send_item(KIND_NONE,  32'hdead_beef, 6'd1);
		send_item(K_DEL_HEAD, 32'h0, 6'd0);
		send_item(K_DEL_TAIL, 32'h0, 6'd0);
		send_item(K_INS_POS,  32'h0f0f_0f0f, 6'd2);
		send_item(K_DISPLAY,  32'h0, 6'd0);
		drain_list();

		// Alternate between filling the list to the full limit and emptying it.
		grow = 1'b1;
		at_edge = 0;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			len = sb.slots.size();
			steady = (done_items >= 150 && done_items < 250);
			if (done_items == 100 || done_items == 300)
				drain_list();
			if ((grow && len == CAPACITY) || (!grow && len == 0))
				at_edge++;
			if (at_edge > 3) begin
				grow = !grow;
				at_edge = 0;
			end

			r = $urandom_range(99);
			if (r < 3)
				kind = KIND_NONE;
			else if (r < 12)
				kind = K_DISPLAY;
			else if (r < 12 + (grow ? 70 : 18))
				kind = 3'($urandom_range(2));
			else
				kind = 3'($urandom_range(5, 3));

			if (kind == K_INS_POS && $urandom_range(3) != 0)
				pos = 6'($urandom_range(len + 1, 1));
			else if (kind == K_DEL_POS && len > 0 && $urandom_range(3) != 0)
				pos = 6'($urandom_range(len, 1));
			else
				pos = 6'($urandom_range(63));

			send_item(kind, $urandom(), pos);
			if (kind != KIND_NONE)
				done_items++;
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		do @(posedge clk); while (sb.waiting());
		repeat (CAPACITY + 8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_bounded_positional_list: done, clean");
		end else begin
			$display("tb_bounded_positional_list: done, errors");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_bounded_positional_list: done, errors");
		$finish;
	end

endmodule
